// ----- rtl/ray_rect_intersect_defines.svh -----
// Assertion macros shared by the ray/rectangle intersection RTL.
`ifndef RAY_RECT_INTERSECT_DEFINES_SVH
`define RAY_RECT_INTERSECT_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define RRI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RRI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/rri_pkg.sv -----
// Package: widths, payload types, register map, axis codes and a saturating helper for ray_rect_intersect.
`default_nettype none
package rri_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TEX_BITS      = 16;              // u, v are unsigned Q1.16
    localparam int TEX_W         = TEX_BITS + 1;    // 0 .. 1.0 inclusive
    localparam int PT_W          = 65;              // full-width hit point
    localparam int TN_W          = 33 + TEX_BITS;   // texture numerator width

    // register indexes
    localparam logic [2:0] REG_AXIS   = 3'd0;
    localparam logic [2:0] REG_OFFSET = 3'd1;
    localparam logic [2:0] REG_A_LOW  = 3'd2;
    localparam logic [2:0] REG_A_HIGH = 3'd3;
    localparam logic [2:0] REG_B_LOW  = 3'd4;
    localparam logic [2:0] REG_B_HIGH = 3'd5;

    // plane axis codes
    localparam logic [1:0] AXIS_XY = 2'd0;
    localparam logic [1:0] AXIS_XZ = 2'd1;
    localparam logic [1:0] AXIS_YZ = 2'd2;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] t_lo;
        logic signed [31:0] t_hi;
    } t_ray_in;

    typedef struct packed {
        logic               hit_flag;
        logic signed [31:0] hit_t;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_ray_out;

    function automatic logic signed [31:0] sat32(input logic signed [PT_W-1:0] v);
        logic signed [PT_W-1:0] mx;
        logic signed [PT_W-1:0] mn;
        mx = PT_W'(64'sh7FFF_FFFF);
        mn = -PT_W'(64'sh8000_0000);
        if (v > mx) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < mn) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ray_rect_intersect.sv -----
// Top level: pipelined ray versus axis-aligned rectangle intersection.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------
//  command  | i_start / o_busy             | i_ray  (t_ray_in)
//  result   | o_res_valid (1-cycle strobe) | o_res  (t_ray_out)
//  config   | APB psel/penable/pwrite      | paddr, pwdata, prdata
//
// One ray is taken every cycle; o_busy is always low. The stages are:
// one setup stage, a restoring divider for t that retires one quotient bit
// per stage (FRAC_BITS + 33 stages), interval, multiply and bounds stages,
// a 17-stage divider pair for u and v, and the output register.
// Reset clears every valid bit; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module ray_rect_intersect
    import rri_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire t_ray_in     i_ray,
    output logic             o_res_valid,
    output t_ray_out         o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
`include "ray_rect_intersect_defines.svh"

    localparam int NW  = 33 + FRAC_BITS;   // quotient magnitude width
    localparam int TW  = NW + 1;           // signed t width
    localparam int LAT = NW + 22;          // accept to result strobe
    localparam int TS  = TEX_W;            // texture divider stages

    // ---------------- configuration registers ----------------
    logic [1:0]         r_axis;
    logic signed [31:0] r_offset, r_a_low, r_a_high, r_b_low, r_b_high;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis   <= AXIS_XY;
            r_offset <= '0;
            r_a_low  <= '0;
            r_a_high <= 32'sd65536;
            r_b_low  <= '0;
            r_b_high <= 32'sd65536;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_AXIS:   r_axis   <= pwdata[1:0];
                REG_OFFSET: r_offset <= pwdata;
                REG_A_LOW:  r_a_low  <= pwdata;
                REG_A_HIGH: r_a_high <= pwdata;
                REG_B_LOW:  r_b_low  <= pwdata;
                REG_B_HIGH: r_b_high <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_AXIS:   prdata = {30'd0, r_axis};
            REG_OFFSET: prdata = r_offset;
            REG_A_LOW:  prdata = r_a_low;
            REG_A_HIGH: prdata = r_a_high;
            REG_B_LOW:  prdata = r_b_low;
            REG_B_HIGH: prdata = r_b_high;
            default:    prdata = '0;
        endcase
    end

    // user keeps config static for rays in flight, unchecked; stages read it as-is
    logic axis_ok;
    assign axis_ok = (r_axis == AXIS_XY) || (r_axis == AXIS_XZ) || (r_axis == AXIS_YZ);

    // ---------------- command accept ----------------
    logic accept;
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // ---------------- stage 1: pick normal axis, set up division ----------------
    logic signed [31:0] n_org_n, n_dir_n;
    logic signed [32:0] n_diff;
    logic [32:0]        n_dmag;

    always_comb begin
        case (r_axis)
            AXIS_XZ: begin n_org_n = i_ray.origin_y; n_dir_n = i_ray.dir_y; end
            AXIS_YZ: begin n_org_n = i_ray.origin_x; n_dir_n = i_ray.dir_x; end
            default: begin n_org_n = i_ray.origin_z; n_dir_n = i_ray.dir_z; end
        endcase
        n_diff = {r_offset[31], r_offset} - {n_org_n[31], n_org_n};
        n_dmag = n_diff[32] ? 33'(-n_diff) : n_diff;
    end

    logic          r1_v, r1_ok, r1_neg;
    t_ray_in       r1_ray;
    logic [NW-1:0] r1_num;
    logic [31:0]   r1_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= accept;
    end

    always_ff @(posedge i_clk) begin
        r1_ray <= i_ray;
        r1_ok  <= axis_ok && (n_dir_n != 32'sd0);
        r1_neg <= n_diff[32] ^ n_dir_n[31];
        r1_num <= {n_dmag, {FRAC_BITS{1'b0}}};
        r1_den <= n_dir_n[31] ? 32'(-n_dir_n) : n_dir_n;
    end

    // ---------------- t divider: one quotient bit per stage ----------------
    logic          rd_v   [NW];
    logic          rd_ok  [NW];
    logic          rd_neg [NW];
    t_ray_in       rd_ray [NW];
    logic [31:0]   rd_den [NW];
    logic [32:0]   rd_rem [NW];
    logic [NW-1:0] rd_nq  [NW];   // numerator bits shift out, quotient bits shift in

    for (genvar k = 0; k < NW; k++) begin : g_div
        logic          in_v, in_ok, in_neg, n_ge;
        t_ray_in       in_ray;
        logic [31:0]   in_den;
        logic [32:0]   in_rem, n_sh;
        logic [NW-1:0] in_nq;

        if (k == 0) begin : g_first
            assign in_v = r1_v;   assign in_ok = r1_ok;   assign in_neg = r1_neg;
            assign in_ray = r1_ray; assign in_den = r1_den;
            assign in_rem = '0;   assign in_nq = r1_num;
        end else begin : g_next
            assign in_v = rd_v[k-1];   assign in_ok = rd_ok[k-1];
            assign in_neg = rd_neg[k-1]; assign in_ray = rd_ray[k-1];
            assign in_den = rd_den[k-1]; assign in_rem = rd_rem[k-1];
            assign in_nq = rd_nq[k-1];
        end

        assign n_sh = {in_rem[31:0], in_nq[NW-1]};
        assign n_ge = n_sh >= {1'b0, in_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) rd_v[k] <= 1'b0;
            else          rd_v[k] <= in_v;
        end

        always_ff @(posedge i_clk) begin
            rd_ok[k]  <= in_ok;
            rd_neg[k] <= in_neg;
            rd_ray[k] <= in_ray;
            rd_den[k] <= in_den;
            rd_rem[k] <= n_ge ? n_sh - {1'b0, in_den} : n_sh;
            rd_nq[k]  <= {in_nq[NW-2:0], n_ge};
        end
    end

    // ---------------- sign and interval test ----------------
    logic signed [TW-1:0] n_t;
    logic                 n_in_iv;

    always_comb begin
        n_t     = rd_neg[NW-1] ? -$signed({1'b0, rd_nq[NW-1]}) : $signed({1'b0, rd_nq[NW-1]});
        n_in_iv = (n_t >= TW'(rd_ray[NW-1].t_lo)) && (n_t <= TW'(rd_ray[NW-1].t_hi));
    end

    logic               r2_v, r2_ok;
    t_ray_in            r2_ray;
    logic signed [31:0] r2_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= rd_v[NW-1];
    end

    always_ff @(posedge i_clk) begin
        r2_ok  <= rd_ok[NW-1] && n_in_iv;
        r2_ray <= rd_ray[NW-1];
        r2_t   <= n_t[31:0];   // in range whenever the test passed
    end

    // ---------------- t * dir ----------------
    logic               r3_v, r3_ok;
    t_ray_in            r3_ray;
    logic signed [31:0] r3_t;
    logic signed [63:0] r3_px, r3_py, r3_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
    end

    always_ff @(posedge i_clk) begin
        r3_ok  <= r2_ok;
        r3_ray <= r2_ray;
        r3_t   <= r2_t;
        r3_px  <= r2_t * r2_ray.dir_x;
        r3_py  <= r2_t * r2_ray.dir_y;
        r3_pz  <= r2_t * r2_ray.dir_z;
    end

    // ---------------- hit point, bounds, texture setup ----------------
    logic signed [PT_W-1:0] n_ptx, n_pty, n_ptz, n_pta, n_ptb;
    logic signed [32:0]     n_wu, n_wv;
    logic signed [PT_W-1:0] n_cu, n_cv;
    logic                   n_inb;

    always_comb begin
        // arithmetic shift of two's complement is the floor
        n_ptx = PT_W'(r3_ray.origin_x) + PT_W'(r3_px >>> FRAC_BITS);
        n_pty = PT_W'(r3_ray.origin_y) + PT_W'(r3_py >>> FRAC_BITS);
        n_ptz = PT_W'(r3_ray.origin_z) + PT_W'(r3_pz >>> FRAC_BITS);
        case (r_axis)
            AXIS_XZ: begin n_pta = n_ptx; n_ptb = n_ptz; end
            AXIS_YZ: begin n_pta = n_pty; n_ptb = n_ptz; end
            default: begin n_pta = n_ptx; n_ptb = n_pty; end
        endcase
        n_inb = (n_pta >= PT_W'(r_a_low)) && (n_pta <= PT_W'(r_a_high)) &&
                (n_ptb >= PT_W'(r_b_low)) && (n_ptb <= PT_W'(r_b_high));
        n_wu  = 33'(r_a_high) - 33'(r_a_low);
        n_wv  = 33'(r_b_high) - 33'(r_b_low);
        n_cu  = n_pta - PT_W'(r_a_low);
        n_cv  = n_ptb - PT_W'(r_b_low);
    end

    logic               r4_v, r4_ok, r4_zu, r4_zv;
    logic signed [31:0] r4_t, r4_x, r4_y, r4_z;
    logic [TN_W-1:0]    r4_nu, r4_nv;
    logic [31:0]        r4_wu, r4_wv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
    end

    always_ff @(posedge i_clk) begin
        r4_ok <= r3_ok && n_inb;
        r4_t  <= r3_t;
        r4_x  <= sat32(n_ptx);
        r4_y  <= sat32(n_pty);
        r4_z  <= sat32(n_ptz);
        // inside the bounds: 0 <= coord - low <= width < 2^32
        r4_nu <= {n_cu[32:0], {TEX_BITS{1'b0}}};
        r4_nv <= {n_cv[32:0], {TEX_BITS{1'b0}}};
        r4_wu <= n_wu[31:0];
        r4_wv <= n_wv[31:0];
        r4_zu <= (n_wu == 33'sd0);
        r4_zv <= (n_wv == 33'sd0);
    end

    // ---------------- u, v dividers: quotient fits TEX_W bits ----------------
    logic               rt_v   [TS];
    logic               rt_ok  [TS];
    logic               rt_zu  [TS];
    logic               rt_zv  [TS];
    logic signed [31:0] rt_t   [TS];
    logic signed [31:0] rt_x   [TS];
    logic signed [31:0] rt_y   [TS];
    logic signed [31:0] rt_z   [TS];
    logic [31:0]        rt_wu  [TS];
    logic [31:0]        rt_wv  [TS];
    logic [TN_W-1:0]    rt_ru  [TS];
    logic [TN_W-1:0]    rt_rv  [TS];
    logic [TEX_W-1:0]   rt_qu  [TS];
    logic [TEX_W-1:0]   rt_qv  [TS];

    for (genvar j = 0; j < TS; j++) begin : g_tex
        localparam int SH = TS - 1 - j;
        logic               in_v, in_ok, in_zu, in_zv, n_geu, n_gev;
        logic signed [31:0] in_t, in_x, in_y, in_z;
        logic [31:0]        in_wu, in_wv;
        logic [TN_W-1:0]    in_ru, in_rv, n_du, n_dv;
        logic [TEX_W-1:0]   in_qu, in_qv;

        if (j == 0) begin : g_first
            assign in_v = r4_v;   assign in_ok = r4_ok;  assign in_zu = r4_zu;
            assign in_zv = r4_zv; assign in_t = r4_t;    assign in_x = r4_x;
            assign in_y = r4_y;   assign in_z = r4_z;    assign in_wu = r4_wu;
            assign in_wv = r4_wv; assign in_ru = r4_nu;  assign in_rv = r4_nv;
            assign in_qu = '0;    assign in_qv = '0;
        end else begin : g_next
            assign in_v = rt_v[j-1];   assign in_ok = rt_ok[j-1]; assign in_zu = rt_zu[j-1];
            assign in_zv = rt_zv[j-1]; assign in_t = rt_t[j-1];   assign in_x = rt_x[j-1];
            assign in_y = rt_y[j-1];   assign in_z = rt_z[j-1];   assign in_wu = rt_wu[j-1];
            assign in_wv = rt_wv[j-1]; assign in_ru = rt_ru[j-1]; assign in_rv = rt_rv[j-1];
            assign in_qu = rt_qu[j-1]; assign in_qv = rt_qv[j-1];
        end

        assign n_du  = TN_W'(in_wu) << SH;
        assign n_dv  = TN_W'(in_wv) << SH;
        assign n_geu = in_ru >= n_du;
        assign n_gev = in_rv >= n_dv;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) rt_v[j] <= 1'b0;
            else          rt_v[j] <= in_v;
        end

        always_ff @(posedge i_clk) begin
            rt_ok[j] <= in_ok;  rt_zu[j] <= in_zu;  rt_zv[j] <= in_zv;
            rt_t[j]  <= in_t;   rt_x[j]  <= in_x;   rt_y[j]  <= in_y;
            rt_z[j]  <= in_z;   rt_wu[j] <= in_wu;  rt_wv[j] <= in_wv;
            rt_ru[j] <= n_geu ? in_ru - n_du : in_ru;
            rt_rv[j] <= n_gev ? in_rv - n_dv : in_rv;
            rt_qu[j] <= {in_qu[TEX_W-2:0], n_geu};
            rt_qv[j] <= {in_qv[TEX_W-2:0], n_gev};
        end
    end

    // ---------------- output register ----------------
    logic     r_out_v;
    t_ray_out r_out, n_out;

    always_comb begin
        n_out = '0;
        if (rt_ok[TS-1]) begin
            n_out.hit_flag = 1'b1;
            n_out.hit_t    = rt_t[TS-1];
            n_out.tex_u    = rt_zu[TS-1] ? '0 : rt_qu[TS-1];
            n_out.tex_v    = rt_zv[TS-1] ? '0 : rt_qv[TS-1];
            n_out.point_x  = rt_x[TS-1];
            n_out.point_y  = rt_y[TS-1];
            n_out.point_z  = rt_z[TS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else          r_out_v <= rt_v[TS-1];
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    // ---------------- assertions ----------------
    // every result strobe traces back to an earlier command transfer
    `RRI_ASSERT_IMP(a_latency, i_clk, i_rst_n, o_res_valid, $past(accept, LAT))
    // a miss carries all-zero fields
    `RRI_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_res_valid && !o_res.hit_flag,
        o_res.hit_t == 32'sd0 && o_res.tex_u == '0 && o_res.tex_v == '0 &&
        o_res.point_x == 32'sd0 && o_res.point_y == 32'sd0 && o_res.point_z == 32'sd0)
    // texture coordinates never exceed 1.0
    `RRI_ASSERT_IMP(a_tex_range, i_clk, i_rst_n, o_res_valid && o_res.hit_flag,
        o_res.tex_u <= 17'd65536 && o_res.tex_v <= 17'd65536)
    // on the xy plane a hit lies inside the x bounds
    `RRI_ASSERT_IMP(a_hit_bounds, i_clk, i_rst_n,
        o_res_valid && o_res.hit_flag && r_axis == AXIS_XY,
        o_res.point_x >= r_a_low && o_res.point_x <= r_a_high)

endmodule
`default_nettype wire
